FILE: hdl/lspd_pkg.sv
`timescale 1ns / 1ps

package lspd_pkg;

    localparam int DIST_W  = 18;
    localparam int ANGLE_W = 16;
    localparam int RUN_W   = 4;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALL      = 2'd0,
        MODE_FORWARD  = 2'd1,
        MODE_BACKWARD = 2'd2,
        MODE_SPARE    = 2'd3
    } sector_mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SECTOR_MODE = 3'd0,
        REG_DANGER_DIST = 3'd1,
        REG_RUN_LENGTH  = 3'd2,
        REG_BAND_LOW    = 3'd3,
        REG_BAND_HIGH   = 3'd4
    } cfg_reg_t;

    localparam logic [DIST_W-1:0]  RESET_DANGER_DIST = 18'd2000;
    localparam logic [RUN_W-1:0]   RESET_RUN_LENGTH  = 4'd3;
    localparam logic [ANGLE_W-1:0] RESET_BAND_LOW    = 16'd10013;
    localparam logic [ANGLE_W-1:0] RESET_BAND_HIGH   = 16'd42780;

    typedef struct packed {
        sector_mode_t        sector_mode;
        logic [DIST_W-1:0]   danger_distance_q2;
        logic [RUN_W-1:0]    run_length;
        logic [ANGLE_W-1:0]  band_low_q14;
        logic [ANGLE_W-1:0]  band_high_q14;
    } cfg_t;

endpackage

FILE: hdl/lspd_cfg_regs.sv
`timescale 1ns / 1ps

module lspd_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lspd_pkg::IDX_W-1:0]      cfg_index,
    input  logic [lspd_pkg::CFG_W-1:0]      cfg_data,
    output lspd_pkg::cfg_t                  cfg
);

    lspd_pkg::cfg_t cfg_reg;
    lspd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (lspd_pkg::cfg_reg_t'(cfg_index))
                lspd_pkg::REG_SECTOR_MODE:
                    cfg_next.sector_mode =
                        lspd_pkg::sector_mode_t'(cfg_data[lspd_pkg::MODE_W-1:0]);
                lspd_pkg::REG_DANGER_DIST:
                    cfg_next.danger_distance_q2 = cfg_data[lspd_pkg::DIST_W-1:0];
                lspd_pkg::REG_RUN_LENGTH:
                    cfg_next.run_length = cfg_data[lspd_pkg::RUN_W-1:0];
                lspd_pkg::REG_BAND_LOW:
                    cfg_next.band_low_q14 = cfg_data[lspd_pkg::ANGLE_W-1:0];
                lspd_pkg::REG_BAND_HIGH:
                    cfg_next.band_high_q14 = cfg_data[lspd_pkg::ANGLE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sector_mode        <= lspd_pkg::MODE_ALL;
            cfg_reg.danger_distance_q2 <= lspd_pkg::RESET_DANGER_DIST;
            cfg_reg.run_length         <= lspd_pkg::RESET_RUN_LENGTH;
            cfg_reg.band_low_q14       <= lspd_pkg::RESET_BAND_LOW;
            cfg_reg.band_high_q14      <= lspd_pkg::RESET_BAND_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/lspd_point_eval.sv
`timescale 1ns / 1ps

module lspd_point_eval
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lspd_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lspd_pkg::DIST_W-1:0]       distance_q2,
    input  logic [lspd_pkg::ANGLE_W-1:0]      angle_q14,
    input  logic                              last_of_scan,
    input  logic                              res_free,
    output logic                              res_valid,
    output logic                              res_obstacle
);

    logic                           pt_valid_reg;
    logic [lspd_pkg::DIST_W-1:0]    pt_dist_reg;
    logic [lspd_pkg::ANGLE_W-1:0]   pt_angle_reg;
    logic                           pt_last_reg;

    logic [lspd_pkg::RUN_W-1:0]     count_reg;
    logic [lspd_pkg::RUN_W-1:0]     count_next;
    logic                           found_reg;
    logic                           found_next;

    logic                           advance;
    logic                           inside_band;
    logic                           in_sector;
    logic                           is_close;
    logic [lspd_pkg::RUN_W-1:0]     need;
    logic [lspd_pkg::RUN_W-1:0]     count_inc;
    logic                           found_upd;

    // A point that closes a scan waits until the result register is free.
    assign advance  = pt_valid_reg && (!pt_last_reg || res_free);
    assign in_ready = !pt_valid_reg || advance;

    assign inside_band = (pt_angle_reg >= cfg.band_low_q14)
                      && (pt_angle_reg <= cfg.band_high_q14);

    always_comb
    begin
        case (cfg.sector_mode)
            lspd_pkg::MODE_FORWARD:  in_sector = !inside_band;
            lspd_pkg::MODE_BACKWARD: in_sector = inside_band;
            default:                 in_sector = 1'b1;
        endcase
    end

    assign is_close  = (pt_dist_reg != '0) && (pt_dist_reg < cfg.danger_distance_q2);
    assign need      = (cfg.run_length == '0) ? lspd_pkg::RUN_W'(1) : cfg.run_length;
    assign count_inc = (count_reg < need) ? count_reg + lspd_pkg::RUN_W'(1) : count_reg;

    always_comb
    begin
        count_next = count_reg;
        found_upd  = found_reg;
        if (in_sector)
        begin
            if (is_close)
            begin
                count_next = count_inc;
                found_upd  = found_reg || (count_inc >= need);
            end
            else
            begin
                count_next = '0;
            end
        end
        found_next = found_upd;
        if (pt_last_reg)
        begin
            count_next = '0;
            found_next = 1'b0;
        end
    end

    assign res_valid    = advance && pt_last_reg;
    assign res_obstacle = found_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= 1'b0;
            count_reg    <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                pt_valid_reg <= in_valid;
            end
            if (advance)
            begin
                count_reg <= count_next;
                found_reg <= found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pt_dist_reg  <= distance_q2;
            pt_angle_reg <= angle_q14;
            pt_last_reg  <= last_of_scan;
        end
    end

endmodule

FILE: hdl/lspd_out_reg.sv
`timescale 1ns / 1ps

module lspd_out_reg
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  logic    res_obstacle,
    output logic    res_free,
    output logic    out_valid,
    input  logic    out_ready,
    output logic    obstacle_close
);

    logic   valid_reg;
    logic   valid_next;
    logic   obstacle_reg;

    assign res_free       = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign obstacle_close = obstacle_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_free)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
        begin
            obstacle_reg <= res_obstacle;
        end
    end

endmodule

FILE: hdl/lidar_sector_proximity_detector_unit.sv
`timescale 1ns / 1ps
//  Channel   Direction  Contents
//  s_axis    in         scan point: distance, angle, end-of-scan mark on tlast
//  m_axis    out        one word per scan: obstacle flag
//  cfg       in         register index and write data
//
//  A point is taken every cycle unless a last point waits in the input register;
//  it is evaluated there against the run counter. The flag of a scan is
//  registered in the output register when its last point leaves the input
//  register. Only a last point waits when the output word is stalled.
//  Reset loads the register defaults and clears the run counter and the flag.

module lidar_sector_proximity_detector_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [17:0] distance_q2, [33:18] angle_q14, [39:34] zero
    input  logic [lspd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] obstacle_close, [7:1] zero
    output logic [lspd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lspd_pkg::IDX_W-1:0]          cfg_index,
    input  logic [lspd_pkg::CFG_W-1:0]          cfg_data
);

    lspd_pkg::cfg_t cfg;
    logic           res_valid;
    logic           res_obstacle;
    logic           res_free;
    logic           obstacle_close;

    lspd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lspd_point_eval u_point_eval
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .distance_q2  (s_axis_tdata[lspd_pkg::DIST_W-1:0]),
        .angle_q14    (s_axis_tdata[lspd_pkg::DIST_W+lspd_pkg::ANGLE_W-1:lspd_pkg::DIST_W]),
        .last_of_scan (s_axis_tlast),
        .res_free     (res_free),
        .res_valid    (res_valid),
        .res_obstacle (res_obstacle)
    );

    lspd_out_reg u_out_reg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res_obstacle   (res_obstacle),
        .res_free       (res_free),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .obstacle_close (obstacle_close)
    );

    assign m_axis_tdata = {{(lspd_pkg::OUT_TDATA_W-1){1'b0}}, obstacle_close};

endmodule

FILE: bench/lspd_flag_checker.sv
`timescale 1ns / 1ps

module lspd_flag_checker
    import lspd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                    s_axis_tlast,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output int                      mismatches,
    output int                      flags_left,
    output int                      flags_seen,
    output int                      flags_raised
);

    cfg_t             regs;
    logic [RUN_W-1:0] close_run;
    logic             obstacle_seen;
    bit               flags_due[$];
    bit               want;
    int               mismatch_count = 0;
    int               pending = 0;
    int               seen_count = 0;
    int               raised_count = 0;

    assign mismatches   = mismatch_count;
    assign flags_left   = pending;
    assign flags_seen   = seen_count;
    assign flags_raised = raised_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    // Advances the run counter and the obstacle flag by one scan point and
    // queues the flag of the scan when the point closes it.
    task automatic score_point(input logic [DIST_W-1:0] point_dist,
                               input logic [ANGLE_W-1:0] angle,
                               input logic last);
        logic [RUN_W-1:0] need;
        logic             in_band;
        logic             in_sector;
        need = (regs.run_length == '0) ? RUN_W'(1) : regs.run_length;
        in_band = (angle >= regs.band_low_q14) && (angle <= regs.band_high_q14);
        case (regs.sector_mode)
            MODE_FORWARD:  in_sector = !in_band;
            MODE_BACKWARD: in_sector = in_band;
            default:       in_sector = 1'b1;
        endcase
        if (in_sector)
        begin
            if (point_dist != '0 && point_dist < regs.danger_distance_q2)
            begin
                if (close_run < need)
                    close_run = close_run + 1'b1;
                if (close_run >= need)
                    obstacle_seen = 1'b1;
            end
            else
            begin
                close_run = '0;
            end
        end
        if (last)
        begin
            flags_due.push_back(obstacle_seen);
            if (obstacle_seen)
                raised_count++;
            close_run = '0;
            obstacle_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.sector_mode        = MODE_ALL;
            regs.danger_distance_q2 = RESET_DANGER_DIST;
            regs.run_length         = RESET_RUN_LENGTH;
            regs.band_low_q14       = RESET_BAND_LOW;
            regs.band_high_q14      = RESET_BAND_HIGH;
            close_run               = '0;
            obstacle_seen           = 1'b0;
            flags_due.delete();
            pending                 = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SECTOR_MODE: regs.sector_mode = sector_mode_t'(cfg_data[MODE_W-1:0]);
                    REG_DANGER_DIST: regs.danger_distance_q2 = cfg_data[DIST_W-1:0];
                    REG_RUN_LENGTH:  regs.run_length = cfg_data[RUN_W-1:0];
                    REG_BAND_LOW:    regs.band_low_q14 = cfg_data[ANGLE_W-1:0];
                    REG_BAND_HIGH:   regs.band_high_q14 = cfg_data[ANGLE_W-1:0];
                    default:         ;
                endcase
            end
            // The output word is compared before the input word of the same
            // edge is scored, since a flag never leaves in the cycle its
            // point is taken.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (flags_due.size() == 0)
                begin
                    report_mismatch("obstacle word arrived with no scan end pending");
                end
                else
                begin
                    want = flags_due.pop_front();
                    seen_count++;
                    if (m_axis_tdata[0] !== want)
                        report_mismatch($sformatf("obstacle_close is %b, expected %b",
                                                  m_axis_tdata[0], want));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                score_point(s_axis_tdata[DIST_W-1:0], s_axis_tdata[DIST_W +: ANGLE_W],
                            s_axis_tlast);
            pending = flags_due.size();
        end
    end

endmodule

FILE: bench/tb_lidar_sector_proximity_detector_unit.sv
`timescale 1ns / 1ps

module tb_lidar_sector_proximity_detector_unit
    import lspd_pkg::*;
();

    localparam int DIST_MAX    = (1 << DIST_W) - 1;
    localparam int ANGLE_MAX   = (1 << ANGLE_W) - 1;
    localparam int RAND_ITEMS  = 1550;
    localparam int RAND_PHASES = 11;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int mismatches;
    int flags_left;
    int flags_seen;
    int flags_raised;

    int  items_sent = 0;
    int  setups = 0;
    int  rx_holds = 0;
    int  cur_danger = int'(RESET_DANGER_DIST);
    int  quiet_cycles = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  rx_hold_req = 1'b0;

    lidar_sector_proximity_detector_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lspd_flag_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .flags_left    (flags_left),
        .flags_seen    (flags_seen),
        .flags_raised  (flags_raised)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Nothing moved for %0d cycles.", STALL_LIMIT);
            $display("[lidar_sector_proximity_detector_unit] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: a random wait before each word, none in quiet phases, and
    // one long hold-off on request so that the block backs up its input.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_holds++;
                gap = HOLD_CYCLES;
            end
            else if (rx_quiet)
            begin
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 11);
            end
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_point(input logic [DIST_W-1:0] point_dist,
                              input logic [ANGLE_W-1:0] angle, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - DIST_W - ANGLE_W){1'b0}}, angle, point_dist};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Stops offering points and waits until every scan flag has come back
    // and the last points have left the pipeline.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (flags_left != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setup(input sector_mode_t mode, input int danger, input int run,
                               input int low, input int high);
        settle();
        write_reg(REG_SECTOR_MODE, int'(mode));
        write_reg(REG_DANGER_DIST, danger);
        write_reg(REG_RUN_LENGTH, run);
        write_reg(REG_BAND_LOW, low);
        write_reg(REG_BAND_HIGH, high);
        cur_danger = danger;
        setups++;
    endtask

    // Distances cluster below the threshold, at it, and at zero, with the
    // rest spread over the whole field.
    function automatic logic [DIST_W-1:0] pick_distance(input int near_pct);
        int roll;
        int edge_val;
        roll = $urandom_range(0, 99);
        if (roll < near_pct && cur_danger > 1)
            return DIST_W'($urandom_range(1, cur_danger - 1));
        if (roll < near_pct + 8)
            return '0;
        if (roll < near_pct + 20)
        begin
            edge_val = cur_danger + int'($urandom_range(0, 2)) - 1;
            if (edge_val < 0)
                edge_val = 0;
            if (edge_val > DIST_MAX)
                edge_val = DIST_MAX;
            return edge_val[DIST_W-1:0];
        end
        return DIST_W'($urandom_range(0, DIST_MAX));
    endfunction

    // A scan sweeps the circle in rising angle order; a disordered scan
    // scatters its angles.
    task automatic send_scan(input int len, input bit ordered, input int near_pct);
        logic [ANGLE_W-1:0] angle;
        int                 stride;
        stride = (ANGLE_MAX + 1) / len;
        angle = ANGLE_W'($urandom_range(0, stride));
        for (int i = 0; i < len; i++)
        begin
            if (ordered)
                angle = angle + ANGLE_W'($urandom_range(0, stride - 1));
            else
                angle = ANGLE_W'($urandom_range(0, ANGLE_MAX));
            send_point(pick_distance(near_pct), angle, i == len - 1);
        end
    endtask

    initial
    begin
        int           target;
        int           base_items;
        int           roll;
        int           near_pct;
        sector_mode_t mode;
        int           danger;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SECTOR_MODE;
        cfg_data      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: three close points in a row raise the flag.
        send_point(1999, 0, 1'b0);
        send_point(1, 16384, 1'b0);
        send_point(1999, ANGLE_W'(ANGLE_MAX), 1'b1);
        // A point at the threshold and an invalid zero distance both break a run.
        send_point(1999, 100, 1'b0);
        send_point(2000, 200, 1'b0);
        send_point(1, 300, 1'b0);
        send_point(0, 400, 1'b1);
        send_point(DIST_W'(DIST_MAX), 500, 1'b1);

        // Spare mode covers all directions and a zero run length acts as one.
        apply_setup(MODE_SPARE, DIST_MAX, 0, ANGLE_MAX, 0);
        send_point(DIST_W'(DIST_MAX - 1), 0, 1'b1);
        send_point(DIST_W'(DIST_MAX), 1, 1'b1);
        // With an inverted band nothing is behind and everything is ahead.
        apply_setup(MODE_BACKWARD, DIST_MAX, 0, ANGLE_MAX, 0);
        send_point(1, 5, 1'b0);
        send_point(1, 6, 1'b1);
        apply_setup(MODE_FORWARD, DIST_MAX, 0, ANGLE_MAX, 0);
        send_point(1, 5, 1'b1);
        // A far point outside the sector leaves the run alone.
        apply_setup(MODE_FORWARD, int'(RESET_DANGER_DIST), 2, int'(RESET_BAND_LOW),
                    int'(RESET_BAND_HIGH));
        send_point(1, 0, 1'b0);
        send_point(5000, 20000, 1'b0);
        send_point(1, 50000, 1'b1);

        base_items = items_sent;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase)
                0: apply_setup(MODE_FORWARD, 1, 1, 0, 0);
                1: apply_setup(MODE_BACKWARD, DIST_MAX, 15, 0, ANGLE_MAX);
                2: apply_setup(MODE_ALL, int'(RESET_DANGER_DIST), int'(RESET_RUN_LENGTH),
                               int'(RESET_BAND_LOW), int'(RESET_BAND_HIGH));
                default:
                begin
                    roll = $urandom_range(0, 9);
                    mode = sector_mode_t'(roll == 9 ? 3 : roll % 3);
                    danger = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DIST_MAX)
                                                         : $urandom_range(100, 20000);
                    apply_setup(mode, danger, $urandom_range(0, 15),
                                $urandom_range(0, ANGLE_MAX), $urandom_range(0, ANGLE_MAX));
                end
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                tx_quiet    = 1'b1;
                rx_hold_req = 1'b1;
            end
            target = base_items + (phase + 1) * (RAND_ITEMS / RAND_PHASES);
            while (items_sent < target)
            begin
                roll = $urandom_range(0, 9);
                case ($urandom_range(0, 2))
                    0:       near_pct = 20;
                    1:       near_pct = 60;
                    default: near_pct = 90;
                endcase
                send_scan($urandom_range(1, roll == 0 ? 3 : 40), roll != 1, near_pct);
            end
        end

        settle();
        $display("Sent %0d scan points under %0d register settings, %0d long output hold-offs.",
                 items_sent, setups + 1, rx_holds);
        $display("Compared %0d obstacle flags, %0d of them raised.", flags_seen, flags_raised);
        if (mismatches == 0 && flags_left == 0)
            $display("[lidar_sector_proximity_detector_unit] OK");
        else
            $display("[lidar_sector_proximity_detector_unit] ERROR");
        $finish;
    end

endmodule
